// File: design/adnp_pkg.sv
// Shared types and constants for the ASCII decimal number parser.
`timescale 1ns / 1ps
`default_nettype none

package adnp_pkg;

    localparam int MAX_CHARS = 11;
    localparam int CHAR_W    = 8;
    localparam int ACC_W     = 44;
    localparam int MANT_W    = 43;
    localparam int CNT_W     = 4;

    localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
    localparam logic [ACC_W-1:0]  ZERO_CODE  = ACC_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

    // Parse state carried from one character to the next.
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic             negative;
        logic             sign_seen;
        logic             point_seen;
        logic [CNT_W-1:0] frac_count;
        logic [CNT_W-1:0] char_count;
    } parse_state_t;

    // Finished number for one string.
    typedef struct packed {
        logic signed [MANT_W-1:0] mantissa;
        logic [CNT_W-1:0]         frac_digits;
        logic                     too_long;
    } parse_result_t;

endpackage

`default_nettype wire

// File: design/adnp_step.sv
// Per-character parse step: next state and the result formed from it.
`timescale 1ns / 1ps
`default_nettype none

module adnp_step (
    input  wire adnp_pkg::parse_state_t      cur,
    input  wire logic [adnp_pkg::CHAR_W-1:0] char_byte,
    output adnp_pkg::parse_state_t           nxt,
    output adnp_pkg::parse_result_t          result
);
    import adnp_pkg::*;

    logic                is_sign;
    logic                is_point;
    logic [ACC_W-1:0]    acc_times10;
    logic [ACC_W-1:0]    acc_digit;
    logic [CNT_W:0]      net_count;
    logic [MANT_W-1:0]   mag;

    assign is_sign     = (char_byte == CHAR_MINUS) || (char_byte == CHAR_PLUS);
    assign is_point    = (char_byte == CHAR_POINT);
    // x*10 = x*8 + x*2, wraps mod 2^44
    assign acc_times10 = (cur.acc << 3) + (cur.acc << 1);
    assign acc_digit   = acc_times10 + {{(ACC_W-CHAR_W){1'b0}}, char_byte} - ZERO_CODE;

    always_comb
    begin
        nxt = cur;
        if (cur.char_count != CNT_MAX)
        begin
            nxt.char_count = cur.char_count + 1'b1;
        end
        if (is_sign)
        begin
            nxt.acc        = '0;
            nxt.point_seen = 1'b0;
            nxt.frac_count = '0;
            nxt.sign_seen  = 1'b1;
            nxt.negative   = (char_byte == CHAR_MINUS);
        end
        else if (is_point)
        begin
            nxt.point_seen = 1'b1;
        end
        else
        begin
            nxt.acc = acc_digit;
            if (cur.point_seen && (cur.frac_count != CNT_MAX))
            begin
                nxt.frac_count = cur.frac_count + 1'b1;
            end
        end
    end

    // sign extension of the 44-bit value does not touch the low 43 bits
    assign mag       = nxt.acc[MANT_W-1:0];
    assign net_count = {1'b0, nxt.char_count} - {{CNT_W{1'b0}}, nxt.sign_seen};

    always_comb
    begin
        if (net_count > (CNT_W+1)'(MAX_CHARS))
        begin
            result.mantissa    = '0;
            result.frac_digits = '0;
            result.too_long    = 1'b1;
        end
        else
        begin
            result.mantissa    = nxt.negative ? -$signed(mag) : $signed(mag);
            result.frac_digits = nxt.frac_count;
            result.too_long    = 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: design/ascii_decimal_number_parser_unit.sv
// Top level of the ASCII decimal number parser.
//
// Input channel: char_byte/last_char with in_valid/in_ready, one character
// per transaction, first character first, last_char set on the final one.
// Output channel: mantissa/frac_digits/too_long with out_valid/out_ready,
// one transaction per string; the number is mantissa / 10^frac_digits.
// Two stages: input register, then parse state and result register.
// Throughput: one character per cycle, except while a final character waits
// for a full output register; the multiply-by-ten and add on the
// accumulator are combinational.
// When the receiver stalls, the result holds in its register; characters
// keep flowing until a final character reaches the parse stage while the
// output register is still full, then in_ready drops until it is taken.
// Reset clears the input and output valid flags and all parse state;
// the block takes a character in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module ascii_decimal_number_parser_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [adnp_pkg::CHAR_W-1:0]         char_byte,
    input  wire logic                                last_char,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [adnp_pkg::MANT_W-1:0]       mantissa,
    output logic [adnp_pkg::CNT_W-1:0]               frac_digits,
    output logic                                     too_long
);
    import adnp_pkg::*;

    logic                 in_valid_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 last_reg;
    parse_state_t         state_reg;
    parse_state_t         state_next;
    parse_result_t        result_next;
    parse_result_t        result_reg;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 in_fire;

    // a final character may only move on when the output slot is free or being taken
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    adnp_step u_step (
        .cur       (state_reg),
        .char_byte (char_reg),
        .nxt       (state_next),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg <= last_reg ? parse_state_t'('0) : state_next;
            end
            if (advance && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            char_reg <= char_byte;
            last_reg <= last_char;
        end
        if (advance && last_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mantissa    = result_reg.mantissa;
    assign frac_digits = result_reg.frac_digits;
    assign too_long    = result_reg.too_long;

endmodule

`default_nettype wire

// File: design/adnp_checker.sv
// Port-level checks for the ASCII decimal number parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module adnp_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire logic [adnp_pkg::CHAR_W-1:0]         char_byte,
    input  wire logic                                last_char,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic signed [adnp_pkg::MANT_W-1:0]  mantissa,
    input  wire logic [adnp_pkg::CNT_W-1:0]          frac_digits,
    input  wire logic                                too_long
);
    import adnp_pkg::*;

    // stalled character transaction must hold
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(char_byte) && $stable(last_char))
        else $error("character changed while stalled");

    // stalled result transaction must hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mantissa)
            && $stable(frac_digits) && $stable(too_long))
        else $error("result changed while stalled");

    // input back-pressure only comes from a full, stalled output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without output stall");

    a_too_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && too_long |-> mantissa == '0 && frac_digits == '0)
        else $error("too_long result not zeroed");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frac_digits <= CNT_W'(MAX_CHARS))
        else $error("frac_digits out of range");

endmodule

bind ascii_decimal_number_parser_unit adnp_checker u_adnp_checker (.*);

`default_nettype wire

// File: tb/tb_ascii_decimal_number_parser_unit.sv
// Self-checking testbench for the ASCII decimal number parser: directed and random strings.
`timescale 1ns / 1ps

module tb_ascii_decimal_number_parser_unit;
    import adnp_pkg::*;

    localparam int LIMIT       = 200000;
    localparam int DRAIN       = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 30;
    localparam int RANDOM_HALF = 500;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              fin;
    } char_item_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [CHAR_W-1:0]        char_byte = '0;
    logic                     last_char = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [MANT_W-1:0] mantissa;
    logic [CNT_W-1:0]         frac_digits;
    logic                     too_long;

    char_item_t    pending_chars[$];
    parse_result_t expected_numbers[$];

    // Running parse of the current string
    logic [ACC_W-1:0] p_acc = '0;
    logic             p_negative = 1'b0;
    logic             p_sign_seen = 1'b0;
    logic             p_point_seen = 1'b0;
    logic [CNT_W-1:0] p_frac = '0;
    logic [CNT_W-1:0] p_len = '0;

    logic in_fire = 1'b0;
    int   cycles = 0;
    int   mismatches = 0;
    int   chars_taken = 0;
    int   numbers_seen = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    // Window with no idling on either side
    wire calm = (chars_taken >= 500) && (chars_taken < 700);

    ascii_decimal_number_parser_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_byte   (char_byte),
        .last_char   (last_char),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mantissa    (mantissa),
        .frac_digits (frac_digits),
        .too_long    (too_long)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic parse_char(input logic [CHAR_W-1:0] code, input logic fin);
        parse_result_t r;
        if (p_len != CNT_MAX)
            p_len = p_len + 1'b1;
        if (code == CHAR_MINUS || code == CHAR_PLUS)
        begin
            // a sign restarts the number
            p_acc        = '0;
            p_point_seen = 1'b0;
            p_frac       = '0;
            p_sign_seen  = 1'b1;
            p_negative   = (code == CHAR_MINUS);
        end
        else if (code == CHAR_POINT)
        begin
            p_point_seen = 1'b1;
        end
        else
        begin
            // any other byte is a digit worth code - '0', wrapping at 44 bits
            p_acc = p_acc * ACC_W'(10) + ACC_W'(code) - ZERO_CODE;
            if (p_point_seen && p_frac != CNT_MAX)
                p_frac = p_frac + 1'b1;
        end
        if (fin)
        begin
            if (int'(p_len) - int'(p_sign_seen) > MAX_CHARS)
            begin
                r.mantissa    = '0;
                r.frac_digits = '0;
                r.too_long    = 1'b1;
            end
            else
            begin
                r.mantissa    = p_negative ? MANT_W'(-p_acc) : MANT_W'(p_acc);
                r.frac_digits = p_frac;
                r.too_long    = 1'b0;
            end
            expected_numbers.push_back(r);
            p_acc        = '0;
            p_negative   = 1'b0;
            p_sign_seen  = 1'b0;
            p_point_seen = 1'b0;
            p_frac       = '0;
            p_len        = '0;
        end
    endtask

    task automatic push_char(input logic [CHAR_W-1:0] code, input logic fin);
        char_item_t item;
        item.code = code;
        item.fin  = fin;
        pending_chars.push_back(item);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endtask

    task automatic drain_all();
        while (pending_chars.size() != 0 || in_valid || expected_numbers.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // Input driver
    always @(negedge clk)
    begin
        char_item_t item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (pending_chars.size() != 0 && (calm || $urandom_range(0, 99) >= 10))
            begin
                item = pending_chars.pop_front();
                char_byte <= item.code;
                last_char <= item.fin;
                in_valid  <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output receiver, with one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && numbers_seen >= HOLD_AFTER)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (calm)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= 10);
        end
    end

    // Monitor: predict on accepted characters, check accepted results
    always @(posedge clk)
    begin
        parse_result_t want;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                parse_char(char_byte, last_char);
                chars_taken <= chars_taken + 1;
            end
            if (out_valid && out_ready)
            begin
                numbers_seen <= numbers_seen + 1;
                if (expected_numbers.size() == 0)
                begin
                    if (mismatches < 10)
                        $display({"%0t: unexpected result mantissa %0d frac_digits %0d ",
                                  "too_long %0b"},
                                 $time, mantissa, frac_digits, too_long);
                    mismatches++;
                end
                else
                begin
                    want = expected_numbers.pop_front();
                    if (mantissa !== want.mantissa || frac_digits !== want.frac_digits ||
                        too_long !== want.too_long)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: exp mantissa %0d frac_digits %0d too_long %0b, ",
                                      "got %0d %0d %0b"},
                                     $time, want.mantissa, want.frac_digits, want.too_long,
                                     mantissa, frac_digits, too_long);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int                random_chars;
        int                n;
        int                pt;
        bit                signed_str;
        bit                nines;
        logic [CHAR_W-1:0] code;
        random_chars = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // lowest and highest byte as lone digits, lone sign, sign and point only,
        // sign dropping earlier digits with extra points, largest negative magnitude
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b1);
        push_text("-");
        push_text("+.");
        push_text("9.-1.2.3");
        push_text("-99999999999");
        drain_all();

        for (int half = 0; half < 2; half++)
        begin
            while (random_chars < RANDOM_HALF * (half + 1))
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    // well-formed number, lengths on both sides of the limit
                    n          = $urandom_range(1, 13);
                    signed_str = 1'($urandom_range(0, 1));
                    nines      = ($urandom_range(0, 99) < 15);
                    if ($urandom_range(0, 99) < 30)
                        pt = -1;
                    else
                        pt = $urandom_range(0, n - 1);
                    for (int i = 0; i < n; i++)
                    begin
                        if (i == 0 && signed_str)
                            code = $urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS;
                        else if (i == pt)
                            code = CHAR_POINT;
                        else if (nines)
                            code = CHAR_NINE;
                        else
                            code = CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
                        push_char(code, i == n - 1);
                    end
                end
                else
                begin
                    // noise: any byte, signs and points anywhere
                    n = $urandom_range(1, 16);
                    for (int i = 0; i < n; i++)
                    begin
                        case ($urandom_range(0, 19))
                            0:       code = CHAR_MINUS;
                            1:       code = CHAR_PLUS;
                            2:       code = CHAR_POINT;
                            default: code = CHAR_W'($urandom_range(0, 255));
                        endcase
                        push_char(code, i == n - 1);
                    end
                end
                random_chars += n;
            end
            drain_all();
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
design/adnp_pkg.sv
design/adnp_step.sv
design/ascii_decimal_number_parser_unit.sv
design/adnp_checker.sv
tb/tb_ascii_decimal_number_parser_unit.sv
